// File: rtl/ordered_list_engine_unit_defines.svh
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OLE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OLE_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLE_ASSERT(label, clk, rst_n, prop, msg)
`define OLE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: rtl/ole_pkg.sv
// shared types and codes of the ordered list engine
package ole_pkg;

	localparam logic [2:0] MODE_INS_FRONT = 3'd0;
	localparam logic [2:0] MODE_INS_REAR  = 3'd1;
	localparam logic [2:0] MODE_INS_AFTER = 3'd2;
	localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [2:0] MODE_DEL_REAR  = 3'd4;
	localparam logic [2:0] MODE_DEL_KEY   = 3'd5;
	localparam logic [2:0] MODE_READ_ALL  = 3'd6;
	localparam logic [2:0] MODE_UNUSED    = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] item;
		logic signed [31:0] key;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic               last;
	} rsp_t;

endpackage

// File: rtl/ole_fifo.sv
// small register queue, used between front and back and at the result side
module ole_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (do_pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule

// File: rtl/ole_front.sv
// front end: range checks command beats on their way into the command queue
module ole_front
	import ole_pkg::*;
(
	input  logic push,
	output logic full,
	input  cmd_t cmd,
	output logic q_push,
	input  logic q_full,
	output cmd_t q_cmd
);
	// the front just decouples; the mode is range checked on the way through
	assign q_push = push;
	assign full   = q_full;
	always_comb begin
		q_cmd = cmd;
		if (cmd.mode > MODE_READ_ALL) q_cmd.mode = MODE_UNUSED;
	end
endmodule

// File: rtl/ole_back.sv
// back end: walks and edits the linked node store, one node read a cycle while walking
module ole_back
	import ole_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic rsp_push,
	output rsp_t rsp,
	input  logic rsp_full
);
`include "ordered_list_engine_unit_defines.svh"
	localparam int PW = $clog2(CAPACITY) + 1;
	localparam int IW = $clog2(CAPACITY);
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WALK = 5'b00010,
		S_READ = 5'b00100,
		S_EDIT = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	logic signed [31:0] val_mem [CAPACITY];
	logic [PW-1:0]      nxt_mem [CAPACITY];

	state_t          state_q;
	cmd_t            cmd_q;
	logic [CAPACITY-1:0] used_q;
	logic [PW-1:0]   head_q, tail_q, cur_q, prev_q;
	logic [PW:0]     cnt_q, n_q;
	logic [1:0]      st_q;
	logic signed [31:0] v_q;
	logic            last_q;
	logic [PW-1:0]   free_idx;
	logic signed [31:0] rd_val;
	logic [PW-1:0]   rd_nxt;
	logic [IW-1:0]   cur_i;
	logic            ptrs_nil;

	assign cur_i  = cur_q[IW-1:0];
	assign rd_val = val_mem[cur_i];
	assign rd_nxt = nxt_mem[cur_i];
	assign ptrs_nil = (head_q == NIL) && (tail_q == NIL);

	// lowest free slot
	always_comb begin
		free_idx = NIL;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (!used_q[i]) free_idx = PW'(i);
	end

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign rsp_push = (state_q == S_OUT) && !rsp_full;
	assign rsp      = '{status: st_q, value: v_q, last: last_q};

	// node store writes and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			head_q  <= NIL;
			tail_q  <= NIL;
			cnt_q   <= '0;
			cmd_q   <= '0;
			cur_q   <= NIL;
			prev_q  <= NIL;
			n_q     <= '0;
			st_q    <= ST_OK;
			v_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
			S_IDLE: if (cmd_valid) begin
				cmd_q  <= cmd;
				cur_q  <= head_q;
				prev_q <= NIL;
				n_q    <= '0;
				v_q    <= '0;
				last_q <= 1'b1;
				unique case (cmd.mode)
				MODE_INS_FRONT, MODE_INS_REAR: begin
					if (cnt_q >= (PW+1)'(CAPACITY)) begin
						st_q    <= ST_FULL;
						state_q <= S_OUT;
					end else begin
						st_q    <= ST_OK;
						state_q <= S_EDIT;
					end
				end
				MODE_INS_AFTER, MODE_DEL_KEY, MODE_DEL_FRONT, MODE_DEL_REAR,
				MODE_READ_ALL: begin
					if (cnt_q == '0) begin
						st_q    <= ST_EMPTY;
						state_q <= S_OUT;
					end else begin
						st_q <= ST_OK;
						if (cmd.mode == MODE_DEL_FRONT) state_q <= S_EDIT;
						else if (cmd.mode == MODE_READ_ALL) state_q <= S_READ;
						else state_q <= S_WALK;
					end
				end
				default: begin
					st_q    <= ST_OK;
					state_q <= S_OUT;
				end
				endcase
			end
			S_WALK: begin
				// search for key, or for the node before the tail
				if (cmd_q.mode == MODE_DEL_REAR) begin
					if (cur_q == tail_q || rd_nxt == tail_q) state_q <= S_EDIT;
					else begin
						prev_q <= cur_q;
						cur_q  <= rd_nxt;
					end
				end else if (rd_val == cmd_q.key) begin
					if (cmd_q.mode == MODE_INS_AFTER && cnt_q >= (PW+1)'(CAPACITY)) begin
						st_q <= ST_FULL;
						state_q <= S_OUT;
					end else state_q <= S_EDIT;
				end else if (n_q + 1'b1 >= cnt_q || rd_nxt == NIL) begin
					st_q <= ST_NOTFOUND;
					state_q <= S_OUT;
				end else begin
					n_q    <= n_q + 1'b1;
					prev_q <= cur_q;
					cur_q  <= rd_nxt;
				end
			end
			S_READ: begin
				v_q    <= rd_val;
				last_q <= (n_q + 1'b1 >= cnt_q) || rd_nxt == NIL;
				state_q <= S_OUT;
			end
			S_EDIT: begin
				state_q <= S_OUT;
				unique case (cmd_q.mode)
				MODE_INS_FRONT: begin
					val_mem[free_idx[IW-1:0]] <= cmd_q.item;
					nxt_mem[free_idx[IW-1:0]] <= head_q;
					used_q[free_idx[IW-1:0]]  <= 1'b1;
					head_q <= free_idx;
					if (cnt_q == '0) tail_q <= free_idx;
					cnt_q <= cnt_q + 1'b1;
				end
				MODE_INS_REAR: begin
					val_mem[free_idx[IW-1:0]] <= cmd_q.item;
					nxt_mem[free_idx[IW-1:0]] <= NIL;
					used_q[free_idx[IW-1:0]]  <= 1'b1;
					if (cnt_q == '0) head_q <= free_idx;
					else nxt_mem[tail_q[IW-1:0]] <= free_idx;
					tail_q <= free_idx;
					cnt_q <= cnt_q + 1'b1;
				end
				MODE_INS_AFTER: begin
					val_mem[free_idx[IW-1:0]] <= cmd_q.item;
					nxt_mem[free_idx[IW-1:0]] <= rd_nxt;
					nxt_mem[cur_i] <= free_idx;
					used_q[free_idx[IW-1:0]] <= 1'b1;
					if (cur_q == tail_q) tail_q <= free_idx;
					cnt_q <= cnt_q + 1'b1;
				end
				MODE_DEL_FRONT: begin
					v_q <= rd_val;
					used_q[cur_i] <= 1'b0;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == (PW+1)'(1)) begin
						head_q <= NIL;
						tail_q <= NIL;
					end else head_q <= rd_nxt;
				end
				MODE_DEL_REAR: begin
					// with one entry the tail goes; otherwise cur is the
					// predecessor of the tail and becomes the new tail
					cnt_q <= cnt_q - 1'b1;
					used_q[tail_q[IW-1:0]] <= 1'b0;
					v_q <= val_mem[tail_q[IW-1:0]];
					if (cnt_q == (PW+1)'(1)) begin
						head_q <= NIL;
						tail_q <= NIL;
					end else begin
						nxt_mem[cur_i] <= NIL;
						tail_q <= cur_q;
					end
				end
				MODE_DEL_KEY: begin
					used_q[cur_i] <= 1'b0;
					cnt_q <= cnt_q - 1'b1;
					if (prev_q != NIL) nxt_mem[prev_q[IW-1:0]] <= rd_nxt;
					if (cnt_q == (PW+1)'(1)) begin
						head_q <= NIL;
						tail_q <= NIL;
					end else begin
						if (prev_q == NIL) head_q <= rd_nxt;
						if (cur_q == tail_q) tail_q <= prev_q;
					end
				end
				default: ;
				endcase
			end
			S_OUT: if (!rsp_full) begin
				if (cmd_q.mode == MODE_READ_ALL && st_q == ST_OK && !last_q) begin
					n_q   <= n_q + 1'b1;
					cur_q <= rd_nxt;
					state_q <= S_READ;
				end else state_q <= S_IDLE;
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	`OLE_ASSERT(a_cnt_cap, clk, arst_n, cnt_q <= (PW+1)'(CAPACITY), "entry count over capacity")
	`OLE_ASSERT(a_used_cnt, clk, arst_n, $countones(used_q) == int'(cnt_q), "map and count differ")
	`OLE_ASSERT(a_empty_nil, clk, arst_n, (cnt_q == '0) |-> ptrs_nil, "empty list has pointers")
	`OLE_ASSERT(a_push_out, clk, arst_n, rsp_push |-> state_q == S_OUT, "result outside output state")
endmodule

// File: rtl/ordered_list_engine_unit.sv
// top level of the ordered list engine
// Singly linked list of up to CAPACITY signed 32-bit values in a node store.
// Commands enter a two-entry queue; the back end takes one command at a time
// and walks the list one node per cycle. Front and rear inserts and front
// delete go from idle to the edit state and then the output state; a refused
// or empty-list command or the unused mode goes straight to the output state.
// A key search walks node by node until the key or the end of the list; a
// rear delete walks to the node before the tail. A read-out takes each entry
// through a read state and an output state. A full result queue stalls the
// back end in its output state. A read-out gives one beat per entry, last on
// the final one.
// Results wait in a two-entry queue. No clearing pass.
module ordered_list_engine_unit
	import ole_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t cmd,
	output logic empty,
	input  logic pop,
	output rsp_t rsp
);
	logic q_push, q_full, q_empty, b_pop, r_push, r_full;
	cmd_t q_cmd, b_cmd;
	rsp_t b_rsp;

	ole_front u_front (
		.push, .full, .cmd,
		.q_push, .q_full, .q_cmd
	);

	ole_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmdq (
		.clk, .arst_n, .push(q_push), .wdata(q_cmd), .full(q_full),
		.pop(b_pop), .rdata(b_cmd), .empty(q_empty)
	);

	ole_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .cmd_valid(!q_empty), .cmd(b_cmd), .cmd_pop(b_pop),
		.rsp_push(r_push), .rsp(b_rsp), .rsp_full(r_full)
	);

	ole_fifo #(.WIDTH($bits(rsp_t)), .DEPTH(2)) u_rspq (
		.clk, .arst_n, .push(r_push), .wdata(b_rsp), .full(r_full),
		.pop, .rdata(rsp), .empty
	);
endmodule

// File: bench/testbench.sv
// self-checking testbench for the ordered list engine
module testbench;
	import ole_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 16;
	localparam int NIL = CAP;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	cmd_t cmd = '0;
	rsp_t rsp;

	// list image tracked by the bench
	logic signed [31:0] list_val [CAP];
	int list_nxt [CAP];
	logic [CAP-1:0] slot_used;
	int list_head;
	int list_tail;
	int list_len;

	rsp_t pending_rsp [$];
	int mismatches = 0;
	int beats_checked = 0;
	int cmds_sent = 0;
	int idle_cycles = 0;
	int pop_hold = 0;
	bit quiet = 1'b0;
	int mode_hits [8];

	ordered_list_engine_unit #(.CAPACITY(CAP)) u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic void add_rsp(logic [1:0] st, logic signed [31:0] v, logic lst);
		rsp_t r;
		r.status = st;
		r.value = v;
		r.last = lst;
		pending_rsp.push_back(r);
	endfunction

	function automatic int take_slot();
		for (int i = 0; i < CAP; i++) begin
			if (!slot_used[i]) begin
				slot_used[i] = 1'b1;
				return i;
			end
		end
		return NIL;
	endfunction

	// first node holding k; prev gets its predecessor
	function automatic int find_key(logic signed [31:0] k, output int prev);
		int cur;
		cur = list_head;
		prev = NIL;
		for (int n = 0; n < list_len && cur < CAP; n++) begin
			if (list_val[cur] == k) return cur;
			prev = cur;
			cur = list_nxt[cur];
		end
		prev = NIL;
		return NIL;
	endfunction

	// apply one command to the list image and queue its results
	function automatic void predict_list_op(cmd_t c);
		int s, p, cur;
		logic signed [31:0] v;
		mode_hits[c.mode]++;
		case (c.mode)
			MODE_INS_FRONT, MODE_INS_REAR: begin
				if (list_len >= CAP) begin
					add_rsp(ST_FULL, 0, 1'b1);
				end else begin
					s = take_slot();
					list_val[s] = c.item;
					if (c.mode == MODE_INS_FRONT) begin
						list_nxt[s] = list_head;
						list_head = s;
						if (list_len == 0) list_tail = s;
					end else begin
						list_nxt[s] = NIL;
						if (list_len == 0) list_head = s;
						else list_nxt[list_tail] = s;
						list_tail = s;
					end
					list_len++;
					add_rsp(ST_OK, 0, 1'b1);
				end
			end
			MODE_INS_AFTER: begin
				if (list_len == 0) begin
					add_rsp(ST_EMPTY, 0, 1'b1);
				end else begin
					cur = find_key(c.key, p);
					if (cur >= CAP) add_rsp(ST_NOTFOUND, 0, 1'b1);
					else if (list_len >= CAP) add_rsp(ST_FULL, 0, 1'b1);
					else begin
						s = take_slot();
						list_val[s] = c.item;
						list_nxt[s] = list_nxt[cur];
						list_nxt[cur] = s;
						if (cur == list_tail) list_tail = s;
						list_len++;
						add_rsp(ST_OK, 0, 1'b1);
					end
				end
			end
			MODE_DEL_FRONT: begin
				if (list_len == 0) begin
					add_rsp(ST_EMPTY, 0, 1'b1);
				end else begin
					s = list_head;
					v = list_val[s];
					list_head = list_nxt[s];
					slot_used[s] = 1'b0;
					list_len--;
					if (list_len == 0) begin
						list_head = NIL;
						list_tail = NIL;
					end
					add_rsp(ST_OK, v, 1'b1);
				end
			end
			MODE_DEL_REAR: begin
				if (list_len == 0) begin
					add_rsp(ST_EMPTY, 0, 1'b1);
				end else if (list_len == 1) begin
					v = list_val[list_head];
					slot_used[list_head] = 1'b0;
					list_head = NIL;
					list_tail = NIL;
					list_len = 0;
					add_rsp(ST_OK, v, 1'b1);
				end else begin
					p = list_head;
					for (int n = 0; n + 2 < list_len; n++) p = list_nxt[p];
					s = list_nxt[p];
					v = list_val[s];
					slot_used[s] = 1'b0;
					list_nxt[p] = NIL;
					list_tail = p;
					list_len--;
					add_rsp(ST_OK, v, 1'b1);
				end
			end
			MODE_DEL_KEY: begin
				if (list_len == 0) begin
					add_rsp(ST_EMPTY, 0, 1'b1);
				end else begin
					cur = find_key(c.key, p);
					if (cur >= CAP) begin
						add_rsp(ST_NOTFOUND, 0, 1'b1);
					end else begin
						if (p >= CAP) list_head = list_nxt[cur];
						else list_nxt[p] = list_nxt[cur];
						if (cur == list_tail) list_tail = p;
						slot_used[cur] = 1'b0;
						list_len--;
						if (list_len == 0) begin
							list_head = NIL;
							list_tail = NIL;
						end
						add_rsp(ST_OK, 0, 1'b1);
					end
				end
			end
			MODE_READ_ALL: begin
				if (list_len == 0) begin
					add_rsp(ST_EMPTY, 0, 1'b1);
				end else begin
					cur = list_head;
					for (int n = 0; n < list_len; n++) begin
						add_rsp(ST_OK, list_val[cur], n == list_len - 1);
						cur = list_nxt[cur];
					end
				end
			end
			default: add_rsp(ST_OK, 0, 1'b1);
		endcase
	endfunction

	// send one command beat, with optional random gap before it
	task automatic send_cmd(logic [2:0] m, logic signed [31:0] itm, logic signed [31:0] k);
		cmd_t c;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		c.mode = m;
		c.item = itm;
		c.key = k;
		push <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (full);
		predict_list_op(c);
		cmds_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// pick a value: often one already in the list so searches hit
	function automatic logic signed [31:0] pick_value();
		int cur, n;
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2, 3: begin
				if (list_len == 0) return $urandom_range(0, 7);
				n = $urandom_range(0, list_len - 1);
				cur = list_head;
				repeat (n) cur = list_nxt[cur];
				return list_val[cur];
			end
			4: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// result side: stall bursts, field compare
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && pop && !empty) begin
			beats_checked++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: status %0d value %0d last %0d",
						rsp.status, rsp.value, rsp.last);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d, got %0d/%0d/%0d",
							want.status, want.value, want.last,
							rsp.status, rsp.value, rsp.last);
				end
			end
		end
		if (quiet || !arst_n) begin
			pop_hold = 0;
			pop <= 1'b1;
		end else if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			pop_hold = $urandom_range(0, 9);
			pop <= 1'b0;
		end else pop <= 1'b1;
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// edge cases on an empty list, then one of each operation
	task automatic test_empty_list();
		for (int m = MODE_INS_AFTER; m <= MODE_READ_ALL; m++)
			send_cmd(3'(m), 0, 0);
		send_cmd(MODE_INS_FRONT, 32'sh8000_0000, 0);
		send_cmd(MODE_INS_REAR, 32'sh7fff_ffff, 0);
		send_cmd(MODE_INS_AFTER, -1, 32'sh8000_0000);
		send_cmd(MODE_INS_AFTER, 5, 32'sh7fff_ffff);
		send_cmd(MODE_INS_AFTER, 6, 12345);
		send_cmd(MODE_READ_ALL, 0, 0);
		send_cmd(MODE_DEL_KEY, 0, 12345);
		send_cmd(MODE_DEL_KEY, 0, 5);
		send_cmd(MODE_DEL_REAR, 0, 0);
		send_cmd(MODE_DEL_FRONT, 0, 0);
		send_cmd(MODE_UNUSED, 32'shffff_ffff, 32'shffff_ffff);
		send_cmd(MODE_DEL_KEY, 0, -1);
		send_cmd(MODE_READ_ALL, 0, 0);
	endtask

	// fill the store, hit the full cases, then drain from both ends
	task automatic test_full_store();
		for (int i = 0; i < CAP; i++) send_cmd(i[0] ? MODE_INS_REAR : MODE_INS_FRONT, i, 0);
		send_cmd(MODE_INS_FRONT, 99, 0);
		send_cmd(MODE_INS_REAR, 99, 0);
		send_cmd(MODE_INS_AFTER, 99, 3);
		send_cmd(MODE_READ_ALL, 0, 0);
		wait_drained();
		repeat (CAP / 2) send_cmd(MODE_DEL_REAR, 0, 0);
		repeat (CAP / 2) send_cmd(MODE_DEL_FRONT, 0, 0);
	endtask

	// random command mix weighted toward a mid-sized list
	task automatic test_random_mix(int count);
		int r;
		logic [2:0] m;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2) m = MODE_UNUSED;
			else if (r < 10) m = MODE_READ_ALL;
			else if (list_len < 8 ? r < 60 : r < 40) m = 3'($urandom_range(0, 2));
			else m = 3'($urandom_range(3, 5));
			send_cmd(m, pick_value(), pick_value());
			// one pause until the engine is drained
			if (i == count / 2) wait_drained();
		end
	endtask

	initial begin
		list_head = NIL;
		list_tail = NIL;
		list_len = 0;
		slot_used = '0;
		foreach (mode_hits[i]) mode_hits[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_full_store();
		test_random_mix(330);
		quiet = 1'b1;
		test_random_mix(40);
		wait_drained();
		repeat (40) @(posedge clk);
		$display("%0d commands sent, %0d result beats checked, %0d read-outs",
			cmds_sent, beats_checked, mode_hits[MODE_READ_ALL]);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d beats missing", mismatches, pending_rsp.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
